[design/assert_macros.svh]
// Assertion helpers. Both expect i_clk in scope; DWMA_ASSERT also expects i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define DWMA_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("dwma check failed in %m");

// Checked on every edge, reset included.
`define DWMA_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("dwma reset check failed in %m");

`endif

[design/dwma_pkg.sv]
`default_nettype none

package dwma_pkg;

    localparam int SAMPLE_W    = 10;   // width of the sample port
    localparam int OUT_W       = 10;   // width of each average port
    localparam int INTERVAL_W  = 16;
    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd100;

    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;
    localparam logic REG_INTERVAL = 1'b0;   // word index of report_interval

    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 3);

    typedef enum logic {
        ACT_SAMPLE = 1'b0,
        ACT_TICK   = 1'b1
    } t_action;

    typedef struct packed {
        logic [OUT_W-1:0] short_avg;
        logic [OUT_W-1:0] long_avg;
    } t_result;

endpackage

`default_nettype wire

[design/dwma_ring.sv]
`default_nettype none

// One window: ring memory with per-entry valid bits, write pointer and
// running sum. The oldest entry is read and overwritten at the same edge;
// the sum is updated in the following cycle from the registered read data.
module dwma_ring
    import dwma_pkg::*;
#(
    parameter int DEPTH  = 8,
    parameter int DATA_W = 10,
    parameter int SUM_W  = DATA_W + $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_wr_en,
    input  wire logic [DATA_W-1:0] i_wr_data,
    output logic      [SUM_W-1:0]  o_sum
);

    localparam int PTR_W = $clog2(DEPTH);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]  r_vld;
    logic [PTR_W-1:0]  r_pos;
    logic [DATA_W-1:0] r_rd;
    logic              r_rd_vld;
    logic [DATA_W-1:0] r_new;
    logic              r_upd;
    logic [SUM_W-1:0]  r_sum;
    logic [SUM_W-1:0]  n_sum;
    logic [DATA_W-1:0] w_old;

    // Read-before-write on the same address; consecutive writes always hit
    // different entries since DEPTH >= 2, so no forwarding is needed.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[r_pos] <= i_wr_data;
        end
        r_rd  <= r_mem[r_pos];
        r_new <= i_wr_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_pos    <= '0;
            r_rd_vld <= 1'b0;
            r_upd    <= 1'b0;
            r_sum    <= '0;
        end else begin
            r_upd    <= i_wr_en;
            r_rd_vld <= r_vld[r_pos];
            if (i_wr_en) begin
                r_vld[r_pos] <= 1'b1;
                r_pos <= (r_pos == PTR_W'(DEPTH - 1)) ? '0 : r_pos + 1'b1;
            end
            if (r_upd) begin
                r_sum <= n_sum;
            end
        end
    end

    // never-written entries count as zero
    assign w_old = r_rd_vld ? r_rd : '0;
    assign n_sum = r_sum - SUM_W'(w_old) + SUM_W'(r_new);
    assign o_sum = r_sum;

endmodule

`default_nettype wire

[design/dwma_div.sv]
`default_nettype none

// Division of a bounded sum by a constant: multiply by a rounded-up
// reciprocal, register, then shift. Exact for every sum below 2**SUM_W.
module dwma_div
    import dwma_pkg::*;
#(
    parameter int DIVISOR = 50,
    parameter int SUM_W   = 16,
    parameter int Q_W     = 10
) (
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic [SUM_W-1:0] i_sum,
    output logic      [Q_W-1:0]   o_quot
);

    localparam int SH     = SUM_W + $clog2(DIVISOR);
    localparam int M_W    = SUM_W + 1;
    localparam int P_W    = SUM_W + M_W;
    localparam logic [M_W-1:0] RECIP = M_W'(((1 << SH) + DIVISOR - 1) / DIVISOR);

    logic [P_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= P_W'(i_sum) * P_W'(RECIP);
        end
    end

    assign o_quot = r_prod[SH +: Q_W];

endmodule

`default_nettype wire

[design/dual_window_moving_average.sv]
// Channel   Direction  Handshake                 Word
// input     in         i_in_valid / o_in_stall   i_action, i_sample
// result    out        o_out_valid / i_out_stall o_short_average, o_long_average
// config    in         APB write, pready = 1     report_interval at byte address 0
//
// One word is taken every cycle while o_in_stall is low; samples and ticks may follow back to back.
// A reporting tick's result passes the report flag, then the reciprocal multiply, then
// the 4-entry queue, where it becomes valid and can be taken.
// o_in_stall rises only when the queue plus reports in flight would overflow it.
// Synchronous active-low reset clears rings (valid bits), sums, tick counter,
// queue and sets report_interval to 100; no clearing pass is needed.
`default_nettype none

module dual_window_moving_average
    import dwma_pkg::*;
#(
    parameter int SHORT_WINDOW = 8,
    parameter int LONG_WINDOW  = 50,
    parameter int SAMPLE_BITS  = 10
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic                  i_action,
    input  wire logic [SAMPLE_W-1:0]   i_sample,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic      [OUT_W-1:0]      o_short_average,
    output logic      [OUT_W-1:0]      o_long_average,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    localparam int SHORT_SUM_W = SAMPLE_BITS + $clog2(SHORT_WINDOW);
    localparam int LONG_SUM_W  = SAMPLE_BITS + $clog2(LONG_WINDOW);
    localparam int SWIDE_W     = (SAMPLE_BITS > SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
    localparam int QWIDE_W     = (SAMPLE_BITS > OUT_W) ? SAMPLE_BITS : OUT_W;

    logic                   w_in_acc;
    logic                   w_smp_acc;
    logic                   w_rep;
    logic [SWIDE_W-1:0]     w_smp_wide;
    logic [SAMPLE_BITS-1:0] w_smp;

    logic [INTERVAL_W-1:0]  r_interval;
    logic [INTERVAL_W-1:0]  r_tick;
    logic                   r_s1_rep;
    logic                   r_s2_rep;

    logic [SHORT_SUM_W-1:0] w_short_sum;
    logic [LONG_SUM_W-1:0]  w_long_sum;
    logic [SAMPLE_BITS-1:0] w_short_q;
    logic [SAMPLE_BITS-1:0] w_long_q;
    logic [QWIDE_W-1:0]     w_short_qw;
    logic [QWIDE_W-1:0]     w_long_qw;

    t_result                r_fifo [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]  r_wr_ptr;
    logic [FIFO_PTR_W-1:0]  r_rd_ptr;
    logic [FIFO_CNT_W-1:0]  r_count;
    logic [FIFO_CNT_W-1:0]  w_committed;
    logic                   w_push;
    logic                   w_pop;
    logic                   w_cfg_wr;
    t_result                w_push_word;

    // ---- input side ----
    assign w_in_acc   = i_in_valid & ~o_in_stall;
    assign w_smp_acc  = w_in_acc & (t_action'(i_action) == ACT_SAMPLE);
    assign w_rep      = w_in_acc & (t_action'(i_action) == ACT_TICK) &
                        (r_tick >= r_interval);
    assign w_smp_wide = SWIDE_W'(i_sample);
    assign w_smp      = w_smp_wide[SAMPLE_BITS-1:0];

    assign w_cfg_wr = psel & penable & pwrite & pready;
    assign pready   = 1'b1;
    assign prdata   = (paddr[APB_ADDR_W-1] == REG_INTERVAL) ?
                      APB_DATA_W'(r_interval) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval <= INTERVAL_RESET;
            r_tick     <= '0;
            r_s1_rep   <= 1'b0;
            r_s2_rep   <= 1'b0;
        end else begin
            if (w_cfg_wr && paddr[APB_ADDR_W-1] == REG_INTERVAL) begin
                r_interval <= pwdata[INTERVAL_W-1:0];
            end
            if (w_in_acc && t_action'(i_action) == ACT_TICK) begin
                r_tick <= w_rep ? '0 : r_tick + 1'b1;
            end
            r_s1_rep <= w_rep;
            r_s2_rep <= r_s1_rep;
        end
    end

    // ---- windows ----
    dwma_ring #(
        .DEPTH  (SHORT_WINDOW),
        .DATA_W (SAMPLE_BITS),
        .SUM_W  (SHORT_SUM_W)
    ) u_short_ring (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_smp_acc),
        .i_wr_data (w_smp),
        .o_sum     (w_short_sum)
    );

    dwma_ring #(
        .DEPTH  (LONG_WINDOW),
        .DATA_W (SAMPLE_BITS),
        .SUM_W  (LONG_SUM_W)
    ) u_long_ring (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_smp_acc),
        .i_wr_data (w_smp),
        .o_sum     (w_long_sum)
    );

    // A report one stage in sees sums that hold every earlier sample.
    dwma_div #(
        .DIVISOR (SHORT_WINDOW),
        .SUM_W   (SHORT_SUM_W),
        .Q_W     (SAMPLE_BITS)
    ) u_short_div (
        .i_clk  (i_clk),
        .i_en   (r_s1_rep),
        .i_sum  (w_short_sum),
        .o_quot (w_short_q)
    );

    dwma_div #(
        .DIVISOR (LONG_WINDOW),
        .SUM_W   (LONG_SUM_W),
        .Q_W     (SAMPLE_BITS)
    ) u_long_div (
        .i_clk  (i_clk),
        .i_en   (r_s1_rep),
        .i_sum  (w_long_sum),
        .o_quot (w_long_q)
    );

    // ---- result queue ----
    assign w_short_qw            = QWIDE_W'(w_short_q);
    assign w_long_qw             = QWIDE_W'(w_long_q);
    assign w_push_word.short_avg = w_short_qw[OUT_W-1:0];
    assign w_push_word.long_avg  = w_long_qw[OUT_W-1:0];

    assign w_push = r_s2_rep;
    assign w_pop  = o_out_valid & ~i_out_stall;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_fifo[r_wr_ptr] <= w_push_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + FIFO_CNT_W'(w_push) - FIFO_CNT_W'(w_pop);
        end
    end

    // queued words plus reports still in the pipe must leave room for one more
    assign w_committed = r_count + FIFO_CNT_W'(r_s1_rep) + FIFO_CNT_W'(r_s2_rep);
    assign o_in_stall  = (w_committed >= FIFO_CNT_W'(FIFO_DEPTH));

    assign o_out_valid     = (r_count != '0);
    assign o_short_average = r_fifo[r_rd_ptr].short_avg;
    assign o_long_average  = r_fifo[r_rd_ptr].long_avg;

endmodule

`default_nettype wire

[design/dwma_checker.sv]
`default_nettype none
`include "assert_macros.svh"

module dwma_checker
    import dwma_pkg::*;
(
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_in_valid,
    input wire logic             o_in_stall,
    input wire logic             i_action,
    input wire logic             o_out_valid,
    input wire logic             i_out_stall,
    input wire logic [OUT_W-1:0] o_short_average,
    input wire logic [OUT_W-1:0] o_long_average
);

    logic w_tick_acc;

    assign w_tick_acc = i_in_valid & ~o_in_stall & (t_action'(i_action) == ACT_TICK);

    // reset empties the result queue
    `DWMA_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !o_out_valid)

    // a waiting word holds while stalled
    `DWMA_ASSERT(a_out_hold, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_short_average) && $stable(o_long_average))

    // a fresh result comes from an accepted tick carried through r_s1_rep and r_s2_rep
    `DWMA_ASSERT(a_result_from_tick, $rose(o_out_valid) |-> $past(w_tick_acc, 3))

    // input is only held off while results are waiting
    `DWMA_ASSERT(a_stall_needs_backlog, o_in_stall |-> o_out_valid)

endmodule

bind dual_window_moving_average dwma_checker u_dwma_checker (.*);

`default_nettype wire

[sim/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import dwma_pkg::*;

    localparam int SHORT_LEN      = 8;
    localparam int LONG_LEN       = 50;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam logic [APB_ADDR_W-1:0] INTERVAL_ADDR = {REG_INTERVAL, 2'b00};
    // no register behind this word
    localparam logic [APB_ADDR_W-1:0] SPARE_ADDR    = INTERVAL_ADDR + 3'd4;

    typedef struct packed {
        t_action             action;
        logic [SAMPLE_W-1:0] sample;
    } t_word;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  i_action    = 1'b0;
    logic [SAMPLE_W-1:0]   i_sample    = '0;
    logic                  i_out_stall = 1'b0;
    logic                  psel        = 1'b0;
    logic                  penable     = 1'b0;
    logic                  pwrite      = 1'b0;
    logic [APB_ADDR_W-1:0] paddr       = '0;
    logic [APB_DATA_W-1:0] pwdata      = '0;

    wire                  o_in_stall;
    wire                  o_out_valid;
    wire [OUT_W-1:0]      o_short_average;
    wire [OUT_W-1:0]      o_long_average;
    wire [APB_DATA_W-1:0] prdata;
    wire                  pready;

    dual_window_moving_average u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_action        (i_action),
        .i_sample        (i_sample),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_short_average (o_short_average),
        .o_long_average  (o_long_average),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    t_word   words_to_send[$];
    t_result expected_avgs[$];
    t_word   in_flight;
    t_result want;

    int send_gap    = 0;
    int stall_left  = 0;
    int gap_pct     = 0;
    int stall_pct   = 0;
    int errors      = 0;
    int idle_cycles = 0;

    // filter state as the block should hold it
    int short_hist[SHORT_LEN];
    int long_hist[LONG_LEN];
    int short_wr, long_wr, short_total, long_total;
    logic [INTERVAL_W-1:0] ticks_seen;
    logic [INTERVAL_W-1:0] interval_cfg;

    task automatic absorb_word(input t_word w);
        t_result r;
        if (w.action == ACT_SAMPLE) begin
            short_total = short_total - short_hist[short_wr] + int'(w.sample);
            short_hist[short_wr] = int'(w.sample);
            short_wr = (short_wr == SHORT_LEN - 1) ? 0 : short_wr + 1;
            long_total = long_total - long_hist[long_wr] + int'(w.sample);
            long_hist[long_wr] = int'(w.sample);
            long_wr = (long_wr == LONG_LEN - 1) ? 0 : long_wr + 1;
        end else if (ticks_seen >= interval_cfg) begin
            ticks_seen = '0;
            r.short_avg = OUT_W'(short_total / SHORT_LEN);
            r.long_avg  = OUT_W'(long_total / LONG_LEN);
            expected_avgs.push_back(r);
        end else begin
            ticks_seen = ticks_seen + 1'b1;
        end
    endtask

    // word driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                absorb_word(in_flight);
            end
            if (!i_in_valid || !o_in_stall) begin
                if (send_gap != 0) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (words_to_send.size() != 0) begin
                    in_flight = words_to_send.pop_front();
                    i_in_valid <= 1'b1;
                    i_action   <= in_flight.action;
                    i_sample   <= in_flight.sample;
                    if ($urandom_range(99) < gap_pct) begin
                        send_gap = $urandom_range(10, 1);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and stall generator
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_avgs.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected word: expected none, got short %0d long %0d",
                             $time, o_short_average, o_long_average);
                end else begin
                    want = expected_avgs.pop_front();
                    if (o_short_average !== want.short_avg) begin
                        errors++;
                        $display("%0t: short_average expected %0d, got %0d",
                                 $time, want.short_avg, o_short_average);
                    end
                    if (o_long_average !== want.long_avg) begin
                        errors++;
                        $display("%0t: long_average expected %0d, got %0d",
                                 $time, want.long_avg, o_long_average);
                    end
                end
            end
            if (stall_left != 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else if ($urandom_range(99) < stall_pct) begin
                stall_left = $urandom_range(9, 0);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || psel) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic push_word(input t_action a, input logic [SAMPLE_W-1:0] s);
        t_word w;
        w.action = a;
        w.sample = s;
        words_to_send.push_back(w);
    endtask

    task automatic apb_write(input logic [APB_ADDR_W-1:0] addr,
                             input logic [APB_DATA_W-1:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == INTERVAL_ADDR) begin
            interval_cfg = data[INTERVAL_W-1:0];
        end
    endtask

    task automatic check_interval();
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= INTERVAL_ADDR;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== APB_DATA_W'(interval_cfg)) begin
            errors++;
            $display("%0t: report_interval readback expected %0d, got %0d",
                     $time, interval_cfg, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // wait until no word is queued or in flight, then let the pipe empty
    task automatic settle();
        do @(negedge i_clk);
        while (words_to_send.size() != 0 || i_in_valid || expected_avgs.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_interval(input logic [INTERVAL_W-1:0] v);
        settle();
        apb_write(INTERVAL_ADDR, APB_DATA_W'(v));
        check_interval();
    endtask

    task automatic run_phase(input logic [INTERVAL_W-1:0] v, input int n,
                             input int tick_pct, input bit quiet);
        logic [SAMPLE_W-1:0] s;
        set_interval(v);
        if (quiet) begin
            gap_pct   = 0;
            stall_pct = 0;
        end else begin
            gap_pct   = 20 * $urandom_range(2);
            stall_pct = 20 * $urandom_range(2);
        end
        for (int k = 0; k < n; k++) begin
            case ($urandom_range(9))
                0:       s = '0;
                1:       s = '1;
                default: s = SAMPLE_W'($urandom);
            endcase
            push_word(($urandom_range(99) < tick_pct) ? ACT_TICK : ACT_SAMPLE, s);
        end
    endtask

    initial begin
        foreach (short_hist[k]) short_hist[k] = 0;
        foreach (long_hist[k]) long_hist[k] = 0;
        short_wr     = 0;
        long_wr      = 0;
        short_total  = 0;
        long_total   = 0;
        ticks_seen   = '0;
        interval_cfg = INTERVAL_RESET;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        check_interval();

        // reset interval: ticks only count
        push_word(ACT_SAMPLE, '1);
        push_word(ACT_SAMPLE, '0);
        push_word(ACT_SAMPLE, '1);
        push_word(ACT_TICK, '0);
        push_word(ACT_TICK, '1);

        // zero interval: every tick reports; short ring wraps
        set_interval('0);
        push_word(ACT_TICK, '0);
        repeat (8) push_word(ACT_SAMPLE, '1);
        push_word(ACT_TICK, '0);

        // max interval, then drop below the count already reached
        set_interval('1);
        repeat (3) push_word(ACT_TICK, '0);
        set_interval(16'd2);
        apb_write(SPARE_ADDR, '0);
        check_interval();
        push_word(ACT_TICK, '0);
        repeat (3) push_word(ACT_TICK, '0);
        push_word(ACT_SAMPLE, '0);
        push_word(ACT_SAMPLE, 10'd1);
        push_word(ACT_TICK, '0);

        run_phase(16'd100, 150, 85, 1'b0);
        run_phase(16'd0, 150, 50, 1'b0);
        run_phase(16'hFFFF, 150, 40, 1'b0);
        run_phase(16'd1, 150, 50, 1'b0);
        run_phase(16'd3, 150, 50, 1'b0);
        run_phase(16'd7, 150, 50, 1'b0);
        run_phase(16'd2, 150, 50, 1'b0);
        run_phase(16'd12, 150, 60, 1'b0);
        run_phase(16'd4, 150, 50, 1'b1);

        settle();
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
